/* rtl/scp_pkg.sv */
`default_nettype none

package scp_pkg;

  // Sample and result widths
  localparam int SAMPLE_BITS = 10;
  localparam int NUM_POINTS  = 5;
  localparam int NUM_SEGS    = NUM_POINTS - 1;
  localparam int SEG_W       = 2;
  localparam int PCT_W       = 7;
  localparam int SEG_PCT     = 25;
  localparam int MISS_PCT    = 50;

  // Quotient of offset*25/span never exceeds 25 since offset <= span
  localparam int QUO_W       = 5;
  localparam int NUM_W       = SAMPLE_BITS + QUO_W;

  // Register file
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_ZERO_PCT          = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUARTER_PCT       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HALF_PCT          = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THREE_QUARTER_PCT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FULL_PCT          = 3'd4;

  // One item inside the divider pipeline
  typedef struct packed {
    logic [NUM_W-1:0]       rem;
    logic [SAMPLE_BITS-1:0] span;
    logic [QUO_W-1:0]       quo;
    logic [PCT_W-1:0]       base;
    logic                   bypass;
  } div_item_t;

  // Percentage at the lower end of a segment
  function automatic logic [PCT_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
    logic [PCT_W-1:0] val;
    case (seg)
      2'd0:    val = PCT_W'(0);
      2'd1:    val = PCT_W'(SEG_PCT);
      2'd2:    val = PCT_W'(2 * SEG_PCT);
      default: val = PCT_W'(3 * SEG_PCT);
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* rtl/scp_div.sv */
`default_nettype none

module scp_div import scp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             div_valid,
  output logic                  div_stall,
  input  wire div_item_t        div_item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [PCT_W-1:0]      percent_value
);

  // One quotient bit per stage, most significant first
  logic      stage_valid [QUO_W];
  div_item_t stage_item  [QUO_W];
  logic      stage_adv   [QUO_W];
  logic      out_adv;

  // Output register frees when empty or taken downstream
  assign out_adv = !result_valid || !result_stall;

  genvar j;
  generate
    for (j = 0; j < QUO_W; j++) begin : g_stage
      localparam int SH = QUO_W - 1 - j;
      div_item_t src;
      logic      src_valid;
      div_item_t stage_next;
      logic [NUM_W-1:0] trial;

      if (j == 0) begin : g_first
        assign src       = div_item;
        assign src_valid = div_valid;
      end else begin : g_rest
        assign src       = stage_item[j-1];
        assign src_valid = stage_valid[j-1];
      end

      if (j == QUO_W - 1) begin : g_last
        assign stage_adv[j] = !stage_valid[j] || out_adv;
      end else begin : g_mid
        assign stage_adv[j] = !stage_valid[j] || stage_adv[j+1];
      end

      // Trial subtract of the shifted span
      assign trial = NUM_W'(src.span) << SH;

      always_comb begin
        stage_next = src;
        if (src.rem >= trial) begin
          stage_next.rem     = src.rem - trial;
          stage_next.quo[SH] = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[j] <= 1'b0;
        end else if (stage_adv[j]) begin
          stage_valid[j] <= src_valid;
        end
        if (stage_adv[j]) begin
          stage_item[j] <= stage_next;
        end
      end
    end
  endgenerate

  assign div_stall = !stage_adv[0];

  // Add the segment base, or pass it alone for a bypassed item
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_adv) begin
      result_valid <= stage_valid[QUO_W-1];
    end
    if (out_adv) begin
      if (stage_item[QUO_W-1].bypass) begin
        percent_value <= stage_item[QUO_W-1].base;
      end else begin
        percent_value <= stage_item[QUO_W-1].base + PCT_W'(stage_item[QUO_W-1].quo);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/five_point_sensor_calibration_top.sv */
`default_nettype none
// Pipeline from an accepted sample to its result: clamp, segment select,
// scale, five restoring-divide stages of one quotient bit each, output register.
// Throughput: one item per cycle; each stage holds its item only while the next is full.
// Reset: synchronous, clears every valid bit and loads the breakpoints 0, 255, 511,
// 767 and 1023.
module five_point_sensor_calibration_top import scp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_W-1:0]      paddr,
  input  wire logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire logic [SAMPLE_BITS-1:0] raw_sample,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [PCT_W-1:0]            percent_value
);

  logic [SAMPLE_BITS-1:0] pts [NUM_POINTS];
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  // Breakpoint registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pts[0] <= SAMPLE_BITS'(0);
      pts[1] <= SAMPLE_BITS'(255);
      pts[2] <= SAMPLE_BITS'(511);
      pts[3] <= SAMPLE_BITS'(767);
      pts[4] <= SAMPLE_BITS'(1023);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_ZERO_PCT:          pts[0] <= pwdata[SAMPLE_BITS-1:0];
        REG_QUARTER_PCT:       pts[1] <= pwdata[SAMPLE_BITS-1:0];
        REG_HALF_PCT:          pts[2] <= pwdata[SAMPLE_BITS-1:0];
        REG_THREE_QUARTER_PCT: pts[3] <= pwdata[SAMPLE_BITS-1:0];
        REG_FULL_PCT:          pts[4] <= pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ZERO_PCT:          prdata = DATA_W'(pts[0]);
      REG_QUARTER_PCT:       prdata = DATA_W'(pts[1]);
      REG_HALF_PCT:          prdata = DATA_W'(pts[2]);
      REG_THREE_QUARTER_PCT: prdata = DATA_W'(pts[3]);
      REG_FULL_PCT:          prdata = DATA_W'(pts[4]);
      default:               prdata = '0;
    endcase
  end

  // Pipeline control
  logic      v1, v2, v3;
  logic      adv1, adv2, adv3;
  logic      div_stall;

  assign adv3         = !v3 || !div_stall;
  assign adv2         = !v2 || adv3;
  assign adv1         = !v1 || adv2;
  assign sample_stall = !adv1;

  // Stage 1: clamp to the end breakpoints, low end first
  logic [SAMPLE_BITS-1:0] x1, x1_next;

  always_comb begin
    if (raw_sample < pts[0]) begin
      x1_next = pts[0];
    end else if (raw_sample > pts[NUM_POINTS-1]) begin
      x1_next = pts[NUM_POINTS-1];
    end else begin
      x1_next = raw_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= sample_valid;
    end
    if (adv1) begin
      x1 <= x1_next;
    end
  end

  // Stage 2: pick the first enclosing segment, form offset and span
  logic [SEG_W-1:0]       seg2, seg2_next;
  logic                   hit2, hit2_next;
  logic [SAMPLE_BITS-1:0] off2, off2_next;
  logic [SAMPLE_BITS-1:0] span2, span2_next;
  logic [NUM_SEGS-1:0]    seg_hit;

  always_comb begin
    for (int s = 0; s < NUM_SEGS; s++) begin
      seg_hit[s] = (x1 >= pts[s]) && (x1 <= pts[s+1]);
    end
    seg2_next  = '0;
    hit2_next  = 1'b0;
    off2_next  = '0;
    span2_next = '0;
    // Scan downwards so the lowest matching segment wins
    for (int s = NUM_SEGS - 1; s >= 0; s--) begin
      if (seg_hit[s]) begin
        seg2_next  = SEG_W'(s);
        hit2_next  = 1'b1;
        off2_next  = x1 - pts[s];
        span2_next = pts[s+1] - pts[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      seg2  <= seg2_next;
      hit2  <= hit2_next;
      off2  <= off2_next;
      span2 <= span2_next;
    end
  end

  // Stage 3: scale the offset by 25 and settle the special cases
  div_item_t item3, item3_next;
  logic [NUM_W-1:0] off_w;

  assign off_w = NUM_W'(off2);

  always_comb begin
    item3_next.rem    = (off_w << 4) + (off_w << 3) + off_w;
    item3_next.span   = span2;
    item3_next.quo    = '0;
    item3_next.base   = hit2 ? seg_base(seg2) : PCT_W'(MISS_PCT);
    item3_next.bypass = !hit2 || (span2 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3) begin
      item3 <= item3_next;
    end
  end

  // Division stages and output register
  scp_div u_div (
    .clk           (clk),
    .rst           (rst),
    .div_valid     (v3),
    .div_stall     (div_stall),
    .div_item      (item3),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .percent_value (percent_value)
  );

endmodule

`default_nettype wire
